// ===== hw/rtl/vdm_pkg.sv =====
package vdm_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DistWidth  = 48;
  localparam int unsigned AccWidth   = 64;
  localparam int unsigned MagWidth   = CoordWidth + 1;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned NumWidth   = AccWidth + 16;
  localparam int unsigned QuoWidth   = DistWidth + 1;
  localparam int unsigned CntWidth   = 7;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned ModeWidth  = 3;

  localparam logic [CntWidth-1:0] CanbIters = CntWidth'(MagWidth + 16);
  localparam logic [CntWidth-1:0] RootIters = CntWidth'(NumWidth / 2);
  localparam logic [CntWidth-1:0] QdivIters = CntWidth'(NumWidth);

  localparam logic signed [DistWidth-1:0] OutMax = {1'b0, {(DistWidth-1){1'b1}}};
  localparam logic signed [DistWidth-1:0] OutMin = {1'b1, {(DistWidth-1){1'b0}}};
  localparam logic signed [AccWidth-1:0]  AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0]  AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  localparam logic [AddrWidth-1:0] AddrMetricMode = 3'd0;

  typedef enum logic [ModeWidth-1:0] {
    M_EUCLID    = 3'd0,
    M_EUCLID_SQ = 3'd1,
    M_MANHATTAN = 3'd2,
    M_CHEBYSHEV = 3'd3,
    M_BRAY      = 3'd4,
    M_CANBERRA  = 3'd5,
    M_DOT       = 3'd6
  } mode_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] coord_a;
    logic signed [CoordWidth-1:0] coord_b;
    logic                         last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DistWidth-1:0] distance;
    logic                        divide_by_zero;
    logic                        saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a;
    logic signed [CoordWidth-1:0] b;
    logic [MagWidth-1:0]          ad;
    logic [MagWidth-1:0]          s;
    logic [MagWidth-1:0]          den;
    logic                         last;
    mode_e                        mode;
  } work_t;

  typedef struct packed {
    logic signed [AccWidth-1:0] val;
    logic                       sat;
  } acc_res_t;

  typedef struct packed {
    logic signed [DistWidth-1:0] val;
    logic                        sat;
  } dist_res_t;

  function automatic acc_res_t sat_add(logic signed [AccWidth-1:0] acc,
                                       logic signed [AccWidth-1:0] v);
    logic signed [AccWidth:0] sum;
    acc_res_t r;
    sum = {acc[AccWidth-1], acc} + {v[AccWidth-1], v};
    r.sat = sum[AccWidth] != sum[AccWidth-1];
    if (r.sat) begin
      r.val = v[AccWidth-1] ? AccMin : AccMax;
    end else begin
      r.val = sum[AccWidth-1:0];
    end
    return r;
  endfunction

  function automatic dist_res_t clamp_out(logic signed [AccWidth-1:0] v);
    dist_res_t r;
    if (v > AccWidth'(OutMax)) begin
      r.val = OutMax;
      r.sat = 1'b1;
    end else if (v < AccWidth'(OutMin)) begin
      r.val = OutMin;
      r.sat = 1'b1;
    end else begin
      r.val = v[DistWidth-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic dist_res_t q8_out(logic signed [AccWidth-1:0] v);
    dist_res_t r;
    if (v[AccWidth-1]) begin
      r.val = '0;
      r.sat = 1'b0;
    end else if (v > AccWidth'(OutMax >>> FracBits)) begin
      r.val = OutMax;
      r.sat = 1'b1;
    end else begin
      r.val = {v[DistWidth-FracBits-1:0], {FracBits{1'b0}}};
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vdm_front.sv =====
module vdm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vdm_pkg::in_item_t in_data_i,
  input  vdm_pkg::mode_e    mode_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output vdm_pkg::work_t    push_data_o
);
  import vdm_pkg::*;

  logic   valid_q, valid_d;
  work_t  item_q, item_d;
  logic signed [MagWidth-1:0] ext_a, ext_b, diff, sum;
  logic [MagWidth-1:0] mag_a, mag_b;

  assign in_stall_o   = valid_q && !push_ready_i;
  assign push_valid_o = valid_q;
  assign push_data_o  = item_q;

  always_comb begin
    ext_a  = MagWidth'(in_data_i.coord_a);
    ext_b  = MagWidth'(in_data_i.coord_b);
    diff   = ext_a - ext_b;
    sum    = ext_a + ext_b;
    mag_a  = ext_a[MagWidth-1] ? MagWidth'(-ext_a) : MagWidth'(ext_a);
    mag_b  = ext_b[MagWidth-1] ? MagWidth'(-ext_b) : MagWidth'(ext_b);
    item_d.a    = in_data_i.coord_a;
    item_d.b    = in_data_i.coord_b;
    item_d.ad   = diff[MagWidth-1] ? MagWidth'(-diff) : MagWidth'(diff);
    item_d.s    = sum[MagWidth-1] ? MagWidth'(-sum) : MagWidth'(sum);
    item_d.den  = mag_a + mag_b;
    item_d.last = in_data_i.last_element;
    item_d.mode = mode_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hw/rtl/vdm_queue.sv =====
module vdm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  vdm_pkg::work_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output vdm_pkg::work_t pop_data_o
);
  import vdm_pkg::*;

  work_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/vdm_back.sv =====
module vdm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  vdm_pkg::work_t     pop_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vdm_pkg::out_item_t out_data_o
);
  import vdm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TERM = 8'b0000_0010,
    S_CDIV = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_FIN  = 8'b0001_0000,
    S_ROOT = 8'b0010_0000,
    S_QDIV = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  work_t  it_q, it_d;
  logic signed [AccWidth-1:0] main_q, main_d, sum_q, sum_d, term_q, term_d;
  logic signed [DistWidth-1:0] dist_q, dist_d;
  logic zflag_q, zflag_d, sflag_q, sflag_d;
  logic [AccWidth-1:0] rem_q, rem_d, den_q, den_d;
  logic [NumWidth-1:0] num_q, num_d;
  logic [QuoWidth-1:0] quo_q, quo_d;
  logic over_q, over_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [AccWidth-1:0] div_sh, rt_sh, rt_trial;
  logic [QuoWidth-1:0] div_qn;
  logic div_ge, rt_ge;
  logic [2*MagWidth-1:0] sq;
  logic signed [2*CoordWidth-1:0] prod;
  logic [AccWidth-1:0] pos_main;
  acc_res_t ra, rb;
  dist_res_t rd;

  assign pop_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    div_sh   = {rem_q[AccWidth-2:0], num_q[NumWidth-1]};
    div_ge   = div_sh >= den_q;
    div_qn   = {quo_q[QuoWidth-2:0], div_ge};
    rt_sh    = {rem_q[AccWidth-3:0], num_q[NumWidth-1:NumWidth-2]};
    rt_trial = {{(AccWidth-QuoWidth-2){1'b0}}, quo_q, 2'b01};
    rt_ge    = rt_sh >= rt_trial;
    sq       = it_q.ad * it_q.ad;
    prod     = it_q.a * it_q.b;
    pos_main = main_q[AccWidth-1] ? '0 : main_q;
  end

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    main_d  = main_q;
    sum_d   = sum_q;
    term_d  = term_q;
    dist_d  = dist_q;
    zflag_d = zflag_q;
    sflag_d = sflag_q;
    rem_d   = rem_q;
    den_d   = den_q;
    num_d   = num_q;
    quo_d   = quo_q;
    over_d  = over_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ra = '0;
    rb = '0;
    rd = '0;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          it_d    = pop_data_i;
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        state_d = S_ACC;
        case (it_q.mode)
          M_EUCLID, M_EUCLID_SQ: term_d = AccWidth'(sq);
          M_MANHATTAN, M_CHEBYSHEV, M_BRAY: term_d = AccWidth'(it_q.ad);
          M_DOT: term_d = AccWidth'(prod);
          M_CANBERRA: begin
            term_d = '0;
            if (it_q.den == '0) begin
              zflag_d = 1'b1;
            end else begin
              rem_d   = '0;
              den_d   = AccWidth'(it_q.den);
              num_d   = {it_q.ad, 16'b0, {(NumWidth-MagWidth-16){1'b0}}};
              quo_d   = '0;
              over_d  = 1'b0;
              cnt_d   = CanbIters;
              state_d = S_CDIV;
            end
          end
          default: term_d = '0;
        endcase
      end
      S_CDIV, S_QDIV: begin
        rem_d = div_ge ? div_sh - den_q : div_sh;
        num_d = {num_q[NumWidth-2:0], 1'b0};
        if (!over_q) begin
          quo_d = div_qn;
          if (div_qn[QuoWidth-1:QuoWidth-2] != 2'b00) begin
            over_d = 1'b1;
          end
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          if (state_q == S_CDIV) begin
            term_d  = AccWidth'(quo_d);
            state_d = S_ACC;
          end else begin
            if (over_d) begin
              sflag_d = 1'b1;
              dist_d  = OutMax;
            end else begin
              dist_d = quo_d[DistWidth-1:0];
            end
            state_d = S_DONE;
          end
        end
      end
      S_ACC: begin
        case (it_q.mode)
          M_EUCLID, M_EUCLID_SQ, M_MANHATTAN, M_CANBERRA, M_DOT: begin
            ra      = sat_add(main_q, term_q);
            main_d  = ra.val;
            sflag_d = sflag_q | ra.sat;
          end
          M_CHEBYSHEV: begin
            if (term_q > main_q) begin
              main_d = term_q;
            end
          end
          M_BRAY: begin
            ra      = sat_add(main_q, term_q);
            rb      = sat_add(sum_q, AccWidth'(it_q.s));
            main_d  = ra.val;
            sum_d   = rb.val;
            sflag_d = sflag_q | ra.sat | rb.sat;
          end
          default: ;
        endcase
        state_d = it_q.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        state_d = S_DONE;
        case (it_q.mode)
          M_EUCLID: begin
            rem_d   = '0;
            num_d   = {pos_main, 16'b0};
            quo_d   = '0;
            cnt_d   = RootIters;
            state_d = S_ROOT;
          end
          M_EUCLID_SQ, M_CANBERRA, M_DOT: begin
            rd      = clamp_out(main_q);
            dist_d  = rd.val;
            sflag_d = sflag_q | rd.sat;
          end
          M_MANHATTAN, M_CHEBYSHEV: begin
            rd      = q8_out(main_q);
            dist_d  = rd.val;
            sflag_d = sflag_q | rd.sat;
          end
          M_BRAY: begin
            if (sum_q <= 0) begin
              zflag_d = 1'b1;
              dist_d  = '0;
            end else begin
              rem_d   = '0;
              den_d   = sum_q;
              num_d   = {pos_main, 16'b0};
              quo_d   = '0;
              over_d  = 1'b0;
              cnt_d   = QdivIters;
              state_d = S_QDIV;
            end
          end
          default: dist_d = '0;
        endcase
      end
      S_ROOT: begin
        rem_d = rt_ge ? rt_sh - rt_trial : rt_sh;
        quo_d = {quo_q[QuoWidth-2:0], rt_ge};
        num_d = {num_q[NumWidth-3:0], 2'b00};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          dist_d  = quo_d[DistWidth-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.distance       = dist_q;
          out_d.divide_by_zero = zflag_q;
          out_d.saturated      = sflag_q;
          out_valid_d = 1'b1;
          main_d  = '0;
          sum_d   = '0;
          zflag_d = 1'b0;
          sflag_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      main_q      <= '0;
      sum_q       <= '0;
      zflag_q     <= 1'b0;
      sflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      main_q      <= main_d;
      sum_q       <= sum_d;
      zflag_q     <= zflag_d;
      sflag_q     <= sflag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    term_q <= term_d;
    dist_q <= dist_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    over_q <= over_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

endmodule

// ===== hw/rtl/vector_distance_metric_unit.sv =====
// channel  | signals                             | transfer when
// input    | in_valid_i, in_stall_o, in_data_i    | valid high, stall low
// output   | out_valid_o, out_stall_i, out_data_o | valid high, stall low
// config   | psel, penable, pwrite, paddr, pwdata | setup then access, pready high
// an element passes through the idle, term and acc states in the back engine, canberra adds its divider
// a last element adds the fin and done states, plus the euclid root or the bray-curtis divide
// the divides and the root run as shift-subtract iterations in the back engine
// a two-entry queue parts front and back, the output register parts the result from stall
// reset is asynchronous and clears mode, accumulators, flags and all valid state
module vector_distance_metric_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vdm_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vdm_pkg::out_item_t                out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vdm_pkg::AddrWidth-1:0]     paddr,
  input  logic [vdm_pkg::DataWidth-1:0]     pwdata,
  output logic [vdm_pkg::DataWidth-1:0]     prdata,
  output logic                              pready
);
  import vdm_pkg::*;

  mode_e mode_q, mode_d;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  work_t push_data, pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrMetricMode[2]) ?
                  {{(DataWidth-ModeWidth){1'b0}}, mode_q} : '0;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && pready && paddr[2] == AddrMetricMode[2]) begin
      mode_d = mode_e'(pwdata[ModeWidth-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_EUCLID;
    end else begin
      mode_q <= mode_d;
    end
  end

  vdm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .mode_i       (mode_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  vdm_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  vdm_back u_back (
    .clk_i, .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ===== hw/rtl/vdm_checker.sv =====
module vdm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input vdm_pkg::out_item_t            out_data_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [vdm_pkg::AddrWidth-1:0] paddr,
  input logic [vdm_pkg::DataWidth-1:0] pwdata,
  input logic [vdm_pkg::DataWidth-1:0] prdata,
  input logic                          pready
);
  import vdm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
    |-> prdata == {{(DataWidth-ModeWidth){1'b0}}, $past(pwdata[ModeWidth-1:0])})
    else $error("metric mode readback mismatch");

endmodule

bind vector_distance_metric_unit vdm_checker u_vdm_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o,
  .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
);
